FILE: rtl/wgm_pkg.sv
// Package for the wildcard glob matcher: operation codes, character constants
// and the control bundle shared by the top level and its sub-blocks.
// No dependencies.
package wgm_pkg;

    localparam int unsigned PATTERN_CHARS_DEF = 32;
    localparam int unsigned CHAR_W            = 16;

    localparam logic [CHAR_W-1:0] CODE_STAR  = 16'd42;
    localparam logic [CHAR_W-1:0] CODE_QMARK = 16'd63;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } op_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic text;
        logic finish;
    } ctrl_t;

endpackage

FILE: rtl/wgm_pattern.sv
// Pattern store of the glob matcher: one cell per pattern character with its
// star and question-mark flags, the fill mask and the one-hot end position.
// Depends on wgm_pkg.
module wgm_pattern #(
    parameter int unsigned PATTERN_CHARS = wgm_pkg::PATTERN_CHARS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wgm_pkg::ctrl_t               ctrl,
    input  logic [wgm_pkg::CHAR_W-1:0]   char_code,
    output logic [PATTERN_CHARS-1:0]     star_mask,
    output logic [PATTERN_CHARS-1:0]     hit_mask,
    output logic [PATTERN_CHARS:0]       end_mask
);

    logic [wgm_pkg::CHAR_W-1:0] char_reg [PATTERN_CHARS];
    logic [PATTERN_CHARS-1:0]   star_reg;
    logic [PATTERN_CHARS-1:0]   qmark_reg;
    logic [PATTERN_CHARS-1:0]   valid_reg;
    logic [PATTERN_CHARS-1:0]   valid_next;
    logic [PATTERN_CHARS:0]     end_reg;
    logic [PATTERN_CHARS:0]     end_next;
    logic                       full;
    logic                       store_en;

    assign full     = end_reg[PATTERN_CHARS];
    assign store_en = ctrl.append && !full;

    always_comb begin
        valid_next = valid_reg;
        end_next   = end_reg;
        if (ctrl.clear) begin
            valid_next = '0;
            end_next   = {{PATTERN_CHARS{1'b0}}, 1'b1};
        end else if (store_en) begin
            valid_next = valid_reg | end_reg[PATTERN_CHARS-1:0];
            end_next   = {end_reg[PATTERN_CHARS-1:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            end_reg   <= {{PATTERN_CHARS{1'b0}}, 1'b1};
        end else begin
            valid_reg <= valid_next;
            end_reg   <= end_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < PATTERN_CHARS; i++) begin
            if (store_en && end_reg[i]) begin
                char_reg[i]  <= char_code;
                star_reg[i]  <= (char_code == wgm_pkg::CODE_STAR);
                qmark_reg[i] <= (char_code == wgm_pkg::CODE_QMARK);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PATTERN_CHARS; i++) begin
            star_mask[i] = valid_reg[i] && star_reg[i];
            hit_mask[i]  = valid_reg[i] && !star_reg[i]
                           && (qmark_reg[i] || (char_reg[i] == char_code));
        end
    end

    assign end_mask = end_reg;

    a_end_onehot : assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(end_reg))
        else $error("End position is not one-hot.");

    a_end_beyond_fill : assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg & end_reg[PATTERN_CHARS-1:0]) == '0)
        else $error("End position lies inside the filled pattern.");

    a_clear_rewinds : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |=> (end_reg == {{PATTERN_CHARS{1'b0}}, 1'b1}) && (valid_reg == '0))
        else $error("Clear did not empty the pattern.");

    a_append_grows : assert property (@(posedge aclk) disable iff (!aresetn)
        store_en && !ctrl.clear |=>
            $countones(valid_reg) == $past($countones(valid_reg)) + 1)
        else $error("Append did not grow the pattern by one character.");

endmodule

FILE: rtl/wgm_active.sv
// Active position set of the glob matcher: star closure by a carry chain,
// one-step advance on a text character and the end-of-text match test.
// Depends on wgm_pkg.
module wgm_active #(
    parameter int unsigned PATTERN_CHARS = wgm_pkg::PATTERN_CHARS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  wgm_pkg::ctrl_t           ctrl,
    input  logic [PATTERN_CHARS-1:0] star_mask,
    input  logic [PATTERN_CHARS-1:0] hit_mask,
    input  logic [PATTERN_CHARS:0]   end_mask,
    output logic                     matched
);

    localparam logic [PATTERN_CHARS:0] START = {{PATTERN_CHARS{1'b0}}, 1'b1};

    logic [PATTERN_CHARS:0]   seed_reg;
    logic [PATTERN_CHARS:0]   seed_next;
    logic [PATTERN_CHARS:0]   prop;
    logic [PATTERN_CHARS:0]   gen;
    logic [PATTERN_CHARS:0]   sum;
    logic [PATTERN_CHARS:0]   carry;
    logic [PATTERN_CHARS:0]   closed;
    logic [PATTERN_CHARS-1:0] stay;
    logic [PATTERN_CHARS-1:0] step;

    // The register holds the set before star closure. A run of stars passes
    // activity upwards exactly as a carry ripples through propagate bits.
    assign prop   = {1'b0, star_mask};
    assign gen    = seed_reg & prop;
    assign sum    = prop + gen;
    assign carry  = sum ^ prop ^ gen;
    assign closed = seed_reg | carry;

    assign stay    = closed[PATTERN_CHARS-1:0] & star_mask;
    assign step    = closed[PATTERN_CHARS-1:0] & hit_mask;
    assign matched = |(closed & end_mask);

    always_comb begin
        seed_next = seed_reg;
        if (ctrl.clear || ctrl.append || ctrl.finish) begin
            seed_next = START;
        end else if (ctrl.text) begin
            seed_next = {1'b0, stay} | {step, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= START;
        end else begin
            seed_reg <= seed_next;
        end
    end

endmodule

FILE: rtl/wildcard_glob_matcher_top.sv
// Top level of the wildcard glob matcher: request register, control decode,
// overflow flag and result register. Depends on wgm_pkg, wgm_pattern, wgm_active.
//
// Each request is one character: tuser gives the operation (clear pattern,
// append pattern character, text character, end of text) and tdata the
// 16-bit code unit. Requests are taken at one per cycle while none waits; an
// end-of-text result appears on the master side in the cycle after its request
// leaves the request register. Only an end-of-text request waits, and only
// while the single result register still holds a result not yet taken.
// Pattern '*' matches any run and '?' any one character; characters appended
// beyond PATTERN_CHARS are dropped and flagged until the next clear.
module wildcard_glob_matcher_top #(
    parameter int unsigned PATTERN_CHARS = wgm_pkg::PATTERN_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_code[15:0]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // matched[0], pattern_overflow[1], zeros[7:2]
);

    logic                       in_valid_reg;
    logic                       in_valid_next;
    wgm_pkg::op_t               in_op_reg;
    logic [wgm_pkg::CHAR_W-1:0] in_char_reg;
    logic                       consume;
    wgm_pkg::ctrl_t             ctrl;
    logic                       overflow_reg;
    logic                       overflow_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       matched_reg;
    logic                       report_ovf_reg;
    logic                       matched;
    logic [PATTERN_CHARS-1:0]   star_mask;
    logic [PATTERN_CHARS-1:0]   hit_mask;
    logic [PATTERN_CHARS:0]     end_mask;

    assign consume  = in_valid_reg
                      && ((in_op_reg != wgm_pkg::OP_END) || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    always_comb begin
        ctrl.clear  = consume && (in_op_reg == wgm_pkg::OP_CLEAR);
        ctrl.append = consume && (in_op_reg == wgm_pkg::OP_APPEND);
        ctrl.text   = consume && (in_op_reg == wgm_pkg::OP_TEXT);
        ctrl.finish = consume && (in_op_reg == wgm_pkg::OP_END);
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        overflow_next = overflow_reg;
        if (ctrl.clear) begin
            overflow_next = 1'b0;
        end else if (ctrl.append && end_mask[PATTERN_CHARS]) begin
            overflow_next = 1'b1;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= wgm_pkg::op_t'(s_tuser);
            in_char_reg <= s_tdata;
        end
        if (ctrl.finish) begin
            matched_reg    <= matched;
            report_ovf_reg <= overflow_reg;
        end
    end

    wgm_pattern #(
        .PATTERN_CHARS(PATTERN_CHARS)
    ) u_pattern (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .char_code (in_char_reg),
        .star_mask (star_mask),
        .hit_mask  (hit_mask),
        .end_mask  (end_mask)
    );

    wgm_active #(
        .PATTERN_CHARS(PATTERN_CHARS)
    ) u_active (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .star_mask (star_mask),
        .hit_mask  (hit_mask),
        .end_mask  (end_mask),
        .matched   (matched)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, report_ovf_reg, matched_reg};

    a_single_strobe : assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(ctrl))
        else $error("More than one operation decoded in a cycle.");

    a_result_not_lost : assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !ctrl.finish)
        else $error("A new result would overwrite one not yet taken.");

    a_finish_shows : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.finish |=> m_tvalid)
        else $error("End-of-text request produced no result.");

endmodule
